### hw/rtl/dq_pkg.sv
// shared types and constants for the double-ended queue
package dq_pkg;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_REAR  = 2'd1,
    ACT_DEL_FRONT = 2'd2,
    ACT_DEL_REAR  = 2'd3
  } dq_action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } dq_status_t;

  localparam int unsigned CAP_W = 7;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    dq_action_t         action;
    logic signed [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0]     removed_value;
    dq_status_t             status;
    logic signed [31:0]     front_value;
    logic signed [31:0]     rear_value;
    logic                   is_empty;
    logic                   is_full;
    logic [COUNT_OUT_W-1:0] entry_count;
  } dq_out_t;

endpackage

### hw/rtl/dq_store.sv
// entry memory with one write port and two registered read ports
module dq_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [31:0]   wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic [AW-1:0]        rd_addr_b,
  output logic signed [31:0]   rd_data_a,
  output logic signed [31:0]   rd_data_b
);
  import dq_pkg::*;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic signed [31:0] wr_data_q;
  logic               byp_a;
  logic               byp_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a      <= mem[rd_addr_a];
      rd_b      <= mem[rd_addr_b];
      wr_data_q <= wr_data;
    end
  end

  // same-cycle write to a read address returns the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_a <= 1'b0;
      byp_b <= 1'b0;
    end else if (rd_en) begin
      byp_a <= wr_en && (wr_addr == rd_addr_a);
      byp_b <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  assign rd_data_a = byp_a ? wr_data_q : rd_a;
  assign rd_data_b = byp_b ? wr_data_q : rd_b;

endmodule

### hw/rtl/double_ended_queue_top.sv
// double-ended queue of signed words with front and rear insert and remove
// an accepted item's result is registered in the output register,
// or waits in the skid slot while the receiver stalls the result ahead of it
// throughput: one item per cycle; the input stalls only while the skid slot is full
// reset empties the queue (head and count zero, tail one slot behind head) and sets
// the capacity to 64; the entry memory is not cleared, only written entries are used
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dq_pkg::dq_in_t                in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dq_pkg::dq_out_t               out_item,
  input  logic                          cfg_wr_en,
  input  logic [dq_pkg::CAP_W-1:0]      cfg_wr_data
);
  import dq_pkg::*;

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  // compare width wide enough for both the count and the capacity register
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    wrap_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  // state
  logic [CAP_W-1:0]   capacity;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;        // always head + count - 1, wrapped
  logic [CW-1:0]      count;
  logic signed [31:0] front_word;  // valid while count > 0
  logic signed [31:0] rear_word;

  logic [AW-1:0]      head_next;
  logic [AW-1:0]      tail_next;
  logic [CW-1:0]      count_next;
  logic signed [31:0] front_next;
  logic signed [31:0] rear_next;

  // output slot plus skid slot
  dq_out_t result;
  dq_out_t skid;
  logic    skid_valid;

  // memory side
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic signed [31:0] front2_word; // second word from the front
  logic signed [31:0] rear2_word;  // second word from the rear

  logic               in_acc;
  logic               out_take;
  logic               is_insert;
  logic               overflow;
  logic               underflow;
  logic [CMPW-1:0]    cap_eff;
  logic [CMPW-1:0]    count_ext;
  logic [CMPW-1:0]    count_next_ext;
  logic signed [31:0] removed;
  dq_status_t         status;

  // an item is taken whenever the skid slot is free
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // capacity above the memory depth acts as the depth
  assign cap_eff = (CMPW'(capacity) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(capacity);
  assign count_ext = CMPW'(count);
  assign count_next_ext = CMPW'(count_next);

  assign is_insert = (in_item.action == ACT_INS_FRONT) || (in_item.action == ACT_INS_REAR);
  assign overflow  = is_insert && (count_ext >= cap_eff);
  assign underflow = !is_insert && (count == '0);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    front_next  = front_word;
    rear_next   = rear_word;
    removed     = '0;
    status      = ST_OK;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wrap_dec(head);
    if (overflow) begin
      status = ST_OVERFLOW;
    end else if (underflow) begin
      status  = ST_UNDERFLOW;
      removed = INT_MIN;
    end else begin
      unique case (in_item.action)
        ACT_INS_FRONT: begin
          head_next   = wrap_dec(head);
          count_next  = count + CW'(1);
          front_next  = in_item.value;
          mem_wr_en   = in_acc;
          mem_wr_addr = wrap_dec(head);
          // first word is both front and rear
          if (count == '0) begin
            rear_next = in_item.value;
          end
        end
        ACT_INS_REAR: begin
          tail_next   = wrap_inc(tail);
          count_next  = count + CW'(1);
          rear_next   = in_item.value;
          mem_wr_en   = in_acc;
          mem_wr_addr = wrap_inc(tail);
          if (count == '0) begin
            front_next = in_item.value;
          end
        end
        ACT_DEL_FRONT: begin
          removed    = front_word;
          head_next  = wrap_inc(head);
          count_next = count - CW'(1);
          front_next = front2_word;
        end
        ACT_DEL_REAR: begin
          removed    = rear_word;
          tail_next  = wrap_dec(tail);
          count_next = count - CW'(1);
          rear_next  = rear2_word;
        end
        default: begin
        end
      endcase
    end
  end

  // neighbors of the new front and rear are fetched for the next item
  dq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (in_item.value),
    .rd_en     (in_acc),
    .rd_addr_a (wrap_inc(head_next)),
    .rd_addr_b (wrap_dec(tail_next)),
    .rd_data_a (front2_word),
    .rd_data_b (rear2_word)
  );

  // result of the current item
  dq_out_t fresh;
  always_comb begin
    fresh.removed_value = removed;
    fresh.status        = status;
    fresh.front_value   = (count_next == '0) ? INT_MAX : front_next;
    fresh.rear_value    = (count_next == '0) ? INT_MAX : rear_next;
    fresh.is_empty      = (count_next == '0);
    fresh.is_full       = (count_next_ext >= cap_eff);
    fresh.entry_count   = count_next_ext[COUNT_OUT_W-1:0];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // queue pointers and cached end words
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= AW'(DEPTH - 1);
      count <= '0;
    end else if (in_acc) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      front_word <= front_next;
      rear_word  <= rear_next;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!in_acc) begin
        out_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        result <= skid;
      end else if (in_acc) begin
        result <= fresh;
      end
    end else if (in_acc) begin
      if (out_valid) begin
        skid <= fresh;
      end else begin
        result <= fresh;
      end
    end
  end

  assign out_item = result;

endmodule

### hw/rtl/dq_checker.sv
// port checks for the double-ended queue, bound to the top level
module dq_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input dq_pkg::dq_out_t out_item
);
  import dq_pkg::*;

  // a result held back by the receiver stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_empty |-> out_item.entry_count == '0)
    else $error("empty queue reports entries");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_empty |->
      out_item.front_value == INT_MAX && out_item.rear_value == INT_MAX)
    else $error("empty queue shows a front or rear word");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_UNDERFLOW |->
      out_item.removed_value == INT_MIN && out_item.is_empty)
    else $error("bad underflow result");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_OVERFLOW |->
      out_item.is_full && out_item.removed_value == '0)
    else $error("overflow on a queue that is not full");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### test/tb_top.sv
// self-checking testbench: directed and random deque traffic against a cycle-free shadow deque
module tb_top;
  import dq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  // cycles in which no item is accepted or taken before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // settling wait for margin after the last result has come back
  localparam int SETTLE_CYCLES = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  dq_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dq_out_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  // idle rates in percent, changed per phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  int mismatch_count = 0;

  // shadow copy of the deque state
  logic signed [31:0] shadow_words [QUEUE_DEPTH];
  logic [5:0] shadow_head = '0;
  logic [6:0] shadow_count = '0;
  logic [CAP_W-1:0] shadow_capacity = CAP_RESET;

  // results predicted for accepted items, oldest first
  dq_out_t results_due [$];

  double_ended_queue_top #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // receiver stalls at random, decided at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // apply one request to the shadow deque and return the result it should give
  function automatic dq_out_t deque_step(dq_in_t req);
    dq_out_t res;
    logic [6:0] usable;
    logic [5:0] rear_slot;
    // a capacity beyond the store acts as the store size
    usable = (shadow_capacity > 7'(QUEUE_DEPTH)) ? 7'(QUEUE_DEPTH) : shadow_capacity;
    res = '0;
    res.status = ST_OK;
    case (req.action) inside
      ACT_INS_FRONT, ACT_INS_REAR: begin
        if (shadow_count >= usable) begin
          // refused insert leaves everything as it was
          res.status = ST_OVERFLOW;
        end else if (req.action == ACT_INS_FRONT) begin
          shadow_head = shadow_head - 6'd1;
          shadow_count = shadow_count + 7'd1;
          shadow_words[shadow_head] = req.value;
        end else begin
          shadow_count = shadow_count + 7'd1;
          rear_slot = shadow_head + 6'(shadow_count - 7'd1);
          shadow_words[rear_slot] = req.value;
        end
      end
      default: begin
        if (shadow_count == 7'd0) begin
          res.status = ST_UNDERFLOW;
          res.removed_value = INT_MIN;
        end else if (req.action == ACT_DEL_FRONT) begin
          res.removed_value = shadow_words[shadow_head];
          shadow_head = shadow_head + 6'd1;
          shadow_count = shadow_count - 7'd1;
        end else begin
          rear_slot = shadow_head + 6'(shadow_count - 7'd1);
          res.removed_value = shadow_words[rear_slot];
          shadow_count = shadow_count - 7'd1;
        end
      end
    endcase
    res.is_empty = (shadow_count == 7'd0);
    res.is_full = (shadow_count >= usable);
    res.entry_count = shadow_count;
    if (res.is_empty) begin
      res.front_value = INT_MAX;
      res.rear_value = INT_MAX;
    end else begin
      rear_slot = shadow_head + 6'(shadow_count - 7'd1);
      res.front_value = shadow_words[shadow_head];
      res.rear_value = shadow_words[rear_slot];
    end
    return res;
  endfunction

  task automatic check_field(string field_name, logic [31:0] due_val, logic [31:0] got_val);
    if (got_val !== due_val) begin
      $display("%0t: %s expected %0h got %0h", $time, field_name, due_val, got_val);
      mismatch_count++;
    end
  endtask

  // every result taken by the receiver is compared against the oldest prediction
  always @(posedge clk) begin : result_check
    dq_out_t due;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_item);
        mismatch_count++;
      end else begin
        due = results_due.pop_front();
        check_field("removed_value", due.removed_value, out_item.removed_value);
        check_field("status", 32'(due.status), 32'(out_item.status));
        check_field("front_value", due.front_value, out_item.front_value);
        check_field("rear_value", due.rear_value, out_item.rear_value);
        check_field("is_empty", 32'(due.is_empty), 32'(out_item.is_empty));
        check_field("is_full", 32'(due.is_full), 32'(out_item.is_full));
        check_field("entry_count", 32'(due.entry_count), 32'(out_item.entry_count));
      end
    end
  end

  // hang detector: counts cycles in which neither side moves an item
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // offer one item, entered and left at a falling edge; valid stays high
  // when the next item follows at once
  task automatic send_item(dq_action_t act, logic signed [31:0] word);
    dq_in_t req;
    req.action = act;
    req.value = word;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    // a stalled item is held as is until the block takes it
    while (in_stall !== 1'b0) @(posedge clk);
    results_due.push_back(deque_step(req));
    @(negedge clk);
  endtask

  // stop sending and let every predicted result come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // capacity is only changed while the block is idle
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_results_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_capacity = cap;
  endtask

  // removals on empty, single-entry deque from either end, extreme words
  task automatic test_empty_and_single();
    send_item(ACT_DEL_FRONT, 32'sd0);
    send_item(ACT_DEL_REAR, -32'sd1);
    // insert at the front of an empty deque: word is front and rear
    send_item(ACT_INS_FRONT, INT_MIN);
    send_item(ACT_DEL_REAR, 32'sd0);
    // same from the rear end
    send_item(ACT_INS_REAR, INT_MAX);
    send_item(ACT_DEL_FRONT, 32'sd0);
    send_item(ACT_INS_FRONT, 32'sd0);
    send_item(ACT_INS_REAR, -32'sd1);
    send_item(ACT_INS_FRONT, 32'sh5555_5555);
    send_item(ACT_DEL_REAR, 32'shAAAA_AAAA);
    send_item(ACT_DEL_FRONT, 32'sd0);
    send_item(ACT_DEL_FRONT, 32'sd0);
  endtask

  // zero capacity refuses every insert and reads empty and full together
  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_item(ACT_INS_FRONT, 32'sh1234_5678);
    send_item(ACT_INS_REAR, -32'sd7);
    send_item(ACT_DEL_FRONT, 32'sd0);
  endtask

  task automatic test_capacity_one();
    write_capacity(7'd1);
    send_item(ACT_INS_REAR, 32'sh0F0F_0F0F);
    send_item(ACT_INS_FRONT, 32'shF0F0_F0F0);
    send_item(ACT_DEL_REAR, 32'sd0);
  endtask

  // capacity dropped under the count: held entries stay, full until drained below
  task automatic test_capacity_below_count();
    write_capacity(7'd64);
    send_item(ACT_INS_REAR, 32'sd11);
    send_item(ACT_INS_REAR, 32'sd22);
    send_item(ACT_INS_REAR, 32'sd33);
    write_capacity(7'd2);
    send_item(ACT_INS_FRONT, 32'sd44);
    send_item(ACT_DEL_FRONT, 32'sd0);
    send_item(ACT_DEL_REAR, 32'sd0);
  endtask

  // bursts that lean toward inserts or removals so the deque fills to its
  // limit, wraps around the store and drains to empty; one full drain pause
  task automatic random_traffic(logic [CAP_W-1:0] cap, int n_items,
                                int unsigned tx_pct, int unsigned rx_pct);
    int burst_left;
    int unsigned insert_pct;
    int pause_at;
    dq_action_t act;
    logic signed [31:0] word;
    write_capacity(cap);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    pause_at = $urandom_range(n_items - 1);
    burst_left = 0;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 120);
        case ($urandom_range(2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      burst_left--;
      if ($urandom_range(99) < insert_pct) begin
        act = $urandom_range(1) ? ACT_INS_REAR : ACT_INS_FRONT;
      end else begin
        act = $urandom_range(1) ? ACT_DEL_REAR : ACT_DEL_FRONT;
      end
      // corner words mixed in with fully random ones
      case ($urandom_range(7))
        0: word = INT_MIN;
        1: word = INT_MAX;
        2: word = 32'sd0;
        3: word = -32'sd1;
        default: word = $urandom;
      endcase
      // sender holds off until the block has answered everything
      if (i == pause_at) wait_results_drained();
      send_item(act, word);
    end
  endtask

  // sender idles less than the receiver; capacity above the store acts as 64
  task automatic test_random_slow_receiver();
    random_traffic(7'd127, 250, 29, 66);
    random_traffic(7'd5, 120, 29, 66);
    random_traffic(7'd0, 30, 29, 66);
  endtask

  task automatic test_random_slow_sender();
    random_traffic(7'd64, 250, 66, 29);
    random_traffic(7'd1, 60, 66, 29);
    random_traffic(7'd100, 150, 66, 29);
  endtask

  // no idling on either side: one item per cycle
  task automatic test_random_back_to_back();
    random_traffic(7'd2, 100, 0, 0);
    random_traffic(7'd33, 200, 0, 0);
    random_traffic(7'd64, 190, 0, 0);
  endtask

  initial begin
    // synchronous reset, released at a falling edge
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    tx_idle_pct = 29;
    rx_idle_pct = 66;
    test_empty_and_single();
    test_capacity_zero();
    test_capacity_one();
    test_capacity_below_count();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_back_to_back();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
